// ----- sv/mse_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mse_pkg: shared types and constants of the execute unit
// Opcodes, status codes, beat structs and register file request structs.
// ----------------------------------------------------------------------------
package mse_pkg;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned REG_IDX_W = 5;
  localparam int unsigned REG_COUNT = 32;
  localparam int unsigned LINE_W    = 13;
  localparam int unsigned MADDR_W   = 20;

  // data memory size in bytes
  localparam logic [WORD_W-1:0] MEMORY_BYTES = 32'd1048576;

  // opcodes
  localparam logic [3:0] OP_ADD  = 4'd0;
  localparam logic [3:0] OP_SUB  = 4'd1;
  localparam logic [3:0] OP_MUL  = 4'd2;
  localparam logic [3:0] OP_BEQ  = 4'd3;
  localparam logic [3:0] OP_BNE  = 4'd4;
  localparam logic [3:0] OP_SLT  = 4'd5;
  localparam logic [3:0] OP_J    = 4'd6;
  localparam logic [3:0] OP_LW   = 4'd7;
  localparam logic [3:0] OP_SW   = 4'd8;
  localparam logic [3:0] OP_ADDI = 4'd9;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_REG_ZERO = 2'd1;
  localparam logic [1:0] ST_BAD_TGT  = 2'd2;
  localparam logic [1:0] ST_BAD_MEM  = 2'd3;

  // one decoded instruction
  typedef struct packed {
    logic [3:0]           op;
    logic [4:0]           first_reg;
    logic [4:0]           second_reg;
    logic [4:0]           third_reg;
    logic                 base_used;
    logic [4:0]           base_reg;
    logic signed [31:0]   immediate;
  } in_item_t;

  // one execution result
  typedef struct packed {
    logic [1:0]           status;
    logic [12:0]          next_line;
    logic                 branch_taken;
    logic                 program_end;
    logic                 reg_written;
    logic signed [31:0]   write_value;
    logic                 mem_request;
    logic                 mem_is_store;
    logic [19:0]          mem_address;
    logic signed [31:0]   store_data;
  } out_item_t;

  // register file read addresses
  typedef struct packed {
    logic [REG_IDX_W-1:0] first_idx;
    logic [REG_IDX_W-1:0] second_idx;
    logic [REG_IDX_W-1:0] third_idx;
    logic [REG_IDX_W-1:0] base_idx;
  } rf_raddr_t;

  // register file read data
  typedef struct packed {
    logic [WORD_W-1:0]    first_val;
    logic [WORD_W-1:0]    second_val;
    logic [WORD_W-1:0]    third_val;
    logic [WORD_W-1:0]    base_val;
  } rf_rdata_t;

  // register file write port
  typedef struct packed {
    logic                 en;
    logic [REG_IDX_W-1:0] idx;
    logic [WORD_W-1:0]    data;
  } rf_wr_t;

endpackage
`default_nettype wire

// ----- sv/mips_subset_execute_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mips_subset_execute_unit: execute unit for a small MIPS-like subset
// Executes one decoded instruction per beat against a 32-entry register
// file and a line counter, and returns one result beat per instruction.
// ----------------------------------------------------------------------------
// The unit takes one instruction beat per clock while the result channel does
// not stall: the register file is read into registers on the accept edge, and
// the execute stage then computes the result into the output register once it
// is free, writing the register file and the line counter at the same time.
// Sustained throughput is one instruction per cycle while the output does not
// stall, set by the single execute stage; a write made on the same edge as the
// next read is bypassed. The register file is two dual-read copies with
// per-entry valid bits, so it is usable right after reset with no clearing
// pass. The program length register is written through the cfg port, which
// is always ready, and should only be changed while the unit is idle.
// ----------------------------------------------------------------------------
module mips_subset_execute_unit (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // instruction channel
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire mse_pkg::in_item_t in_data,
  // result channel
  output logic                   out_valid,
  input  wire logic              out_stall,
  output mse_pkg::out_item_t     out_data,
  // program length register
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [12:0]       cfg_data
);

  logic               exec_valid_r;
  mse_pkg::in_item_t  exec_item_r;
  logic               out_valid_r;
  mse_pkg::out_item_t out_item_r;
  logic [12:0]        line_counter_r;
  logic [12:0]        program_length_r;

  logic               out_free;
  logic               exec_adv;
  logic               accept;
  mse_pkg::rf_raddr_t raddr;
  mse_pkg::rf_rdata_t rdata;
  mse_pkg::rf_wr_t    alu_wr;
  mse_pkg::rf_wr_t    rf_wr;
  mse_pkg::out_item_t alu_res;

  // pipeline handshake
  always_comb begin
    out_free = !out_valid_r || !out_stall;
    exec_adv = exec_valid_r && out_free;
    in_stall = exec_valid_r && !out_free;
    accept   = in_valid && !in_stall;
  end

  // read addresses straight from the incoming beat
  always_comb begin
    raddr.first_idx  = in_data.first_reg;
    raddr.second_idx = in_data.second_reg;
    raddr.third_idx  = in_data.third_reg;
    raddr.base_idx   = in_data.base_reg;
  end

  // write only when the result moves on
  always_comb begin
    rf_wr    = alu_wr;
    rf_wr.en = alu_wr.en && exec_adv;
  end

  mse_regfile u_regfile (
    .clk   (clk),
    .rst_n (rst_n),
    .rd_en (accept),
    .raddr (raddr),
    .wr    (rf_wr),
    .rdata (rdata)
  );

  mse_alu u_alu (
    .item           (exec_item_r),
    .rdata          (rdata),
    .line_counter   (line_counter_r),
    .program_length (program_length_r),
    .res            (alu_res),
    .wr             (alu_wr)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exec_valid_r     <= 1'b0;
      out_valid_r      <= 1'b0;
      line_counter_r   <= '0;
      program_length_r <= '0;
    end else begin
      if (accept) begin
        exec_valid_r <= 1'b1;
      end else if (exec_adv) begin
        exec_valid_r <= 1'b0;
      end
      if (exec_adv) begin
        out_valid_r    <= 1'b1;
        line_counter_r <= alu_res.next_line;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        program_length_r <= cfg_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      exec_item_r <= in_data;
    end
    if (exec_adv) begin
      out_item_r <= alu_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;
  assign cfg_ready = 1'b1;

endmodule
`default_nettype wire

// ----- sv/mse_regfile.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mse_regfile: 32 x 32 register file with four registered read ports
// Two dual-read copies written together, per-entry valid bits for the
// all-zero reset, and a bypass of the write made on the read edge.
// ----------------------------------------------------------------------------
module mse_regfile (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               rd_en,
  input  wire mse_pkg::rf_raddr_t raddr,
  input  wire mse_pkg::rf_wr_t    wr,
  output mse_pkg::rf_rdata_t      rdata
);

  logic [mse_pkg::WORD_W-1:0]    bank_a_r [mse_pkg::REG_COUNT];
  logic [mse_pkg::WORD_W-1:0]    bank_b_r [mse_pkg::REG_COUNT];
  logic [mse_pkg::REG_COUNT-1:0] valid_r;
  mse_pkg::rf_raddr_t            raddr_r;
  mse_pkg::rf_rdata_t            q_r;
  logic                          fwd_valid_r;
  logic [mse_pkg::REG_IDX_W-1:0] fwd_idx_r;
  logic [mse_pkg::WORD_W-1:0]    fwd_data_r;

  // pick the last write when its index matches the read
  function automatic logic [mse_pkg::WORD_W-1:0] bypass(
    input logic [mse_pkg::REG_IDX_W-1:0] idx,
    input logic [mse_pkg::WORD_W-1:0]    q,
    input logic                          fv,
    input logic [mse_pkg::REG_IDX_W-1:0] fi,
    input logic [mse_pkg::WORD_W-1:0]    fd
  );
    return (fv && (idx == fi)) ? fd : q;
  endfunction

  // storage writes, both copies
  always_ff @(posedge clk) begin
    if (wr.en) begin
      bank_a_r[wr.idx] <= wr.data;
      bank_b_r[wr.idx] <= wr.data;
    end
  end

  // registered reads, two per copy; unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (rd_en) begin
      raddr_r            <= raddr;
      q_r.first_val      <= valid_r[raddr.first_idx]  ? bank_a_r[raddr.first_idx]  : '0;
      q_r.second_val     <= valid_r[raddr.second_idx] ? bank_a_r[raddr.second_idx] : '0;
      q_r.third_val      <= valid_r[raddr.third_idx]  ? bank_b_r[raddr.third_idx]  : '0;
      q_r.base_val       <= valid_r[raddr.base_idx]   ? bank_b_r[raddr.base_idx]   : '0;
    end
  end

  // entry valid bits and last-write bypass register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      fwd_valid_r <= 1'b0;
    end else if (wr.en) begin
      valid_r[wr.idx] <= 1'b1;
      fwd_valid_r     <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      fwd_idx_r  <= wr.idx;
      fwd_data_r <= wr.data;
    end
  end

  // read data with bypass
  always_comb begin
    rdata.first_val  = bypass(raddr_r.first_idx, q_r.first_val,
                              fwd_valid_r, fwd_idx_r, fwd_data_r);
    rdata.second_val = bypass(raddr_r.second_idx, q_r.second_val,
                              fwd_valid_r, fwd_idx_r, fwd_data_r);
    rdata.third_val  = bypass(raddr_r.third_idx, q_r.third_val,
                              fwd_valid_r, fwd_idx_r, fwd_data_r);
    rdata.base_val   = bypass(raddr_r.base_idx, q_r.base_val,
                              fwd_valid_r, fwd_idx_r, fwd_data_r);
  end

endmodule
`default_nettype wire

// ----- sv/mse_alu.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mse_alu: instruction execute logic
// Arithmetic, branch target and memory address checks, next line and the
// register write for one instruction.
// ----------------------------------------------------------------------------
module mse_alu (
  input  wire mse_pkg::in_item_t  item,
  input  wire mse_pkg::rf_rdata_t rdata,
  input  wire logic [12:0]        line_counter,
  input  wire logic [12:0]        program_length,
  output mse_pkg::out_item_t      res,
  output mse_pkg::rf_wr_t         wr
);

  logic [31:0] addr;
  logic [29:0] word;
  logic        addr_ok;
  logic        tgt_ok;
  logic        mem_ok;
  logic        take;

  // address: immediate plus optional base, 32-bit wrap
  always_comb begin
    addr    = item.immediate + (item.base_used ? rdata.base_val : 32'd0);
    word    = addr[31:2];
    addr_ok = !addr[31] && (addr[1:0] == 2'b00);
    tgt_ok  = addr_ok && (word <= 30'(program_length));
    mem_ok  = addr_ok && (word >= 30'(program_length)) && (addr < mse_pkg::MEMORY_BYTES);
  end

  // execute
  always_comb begin
    res           = '0;
    res.next_line = line_counter + 13'd1;
    take          = 1'b0;
    if ((item.first_reg == '0) &&
        !(item.op inside {mse_pkg::OP_BEQ, mse_pkg::OP_BNE, mse_pkg::OP_J, mse_pkg::OP_SW})) begin
      res.status = mse_pkg::ST_REG_ZERO;
    end else begin
      case (item.op)
        mse_pkg::OP_ADD: begin
          res.reg_written = 1'b1;
          res.write_value = rdata.second_val + rdata.third_val;
        end
        mse_pkg::OP_SUB: begin
          res.reg_written = 1'b1;
          res.write_value = rdata.second_val - rdata.third_val;
        end
        mse_pkg::OP_MUL: begin
          res.reg_written = 1'b1;
          res.write_value = rdata.second_val * rdata.third_val;
        end
        mse_pkg::OP_SLT: begin
          res.reg_written = 1'b1;
          res.write_value = {31'd0,
                             $signed(rdata.second_val) < $signed(rdata.third_val)};
        end
        mse_pkg::OP_ADDI: begin
          res.reg_written = 1'b1;
          res.write_value = rdata.second_val + item.immediate;
        end
        mse_pkg::OP_BEQ, mse_pkg::OP_BNE, mse_pkg::OP_J: begin
          if (!tgt_ok) begin
            res.status = mse_pkg::ST_BAD_TGT;
          end else begin
            case (item.op)
              mse_pkg::OP_BEQ: take = (rdata.first_val == rdata.second_val);
              mse_pkg::OP_BNE: take = (rdata.first_val != rdata.second_val);
              default:         take = 1'b1;
            endcase
            if (take) begin
              res.branch_taken = 1'b1;
              res.next_line    = word[12:0];
            end
          end
        end
        mse_pkg::OP_LW, mse_pkg::OP_SW: begin
          if (!mem_ok) begin
            res.status = mse_pkg::ST_BAD_MEM;
          end else begin
            res.mem_request  = 1'b1;
            res.mem_is_store = (item.op == mse_pkg::OP_SW);
            res.mem_address  = addr[19:0];
            res.store_data   = (item.op == mse_pkg::OP_SW) ? rdata.first_val : 32'd0;
          end
        end
        default: ;
      endcase
    end
    // any error: nothing happens, counter holds
    if (res.status != mse_pkg::ST_OK) begin
      res.next_line    = line_counter;
      res.branch_taken = 1'b0;
      res.reg_written  = 1'b0;
      res.write_value  = '0;
      res.mem_request  = 1'b0;
      res.mem_is_store = 1'b0;
      res.mem_address  = '0;
      res.store_data   = '0;
    end
    res.program_end = (res.next_line == program_length);
  end

  // register file write request
  always_comb begin
    wr.en   = res.reg_written;
    wr.idx  = item.first_reg;
    wr.data = res.write_value;
  end

endmodule
`default_nettype wire

// ----- sv/mse_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mse_checker: port-level checks for the execute unit
// Watches the result channel and its relation to reset and status.
// ----------------------------------------------------------------------------
module mse_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire mse_pkg::out_item_t out_data
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // no result beat right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // an error blocks all side effects
  a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != mse_pkg::ST_OK) |->
      !out_data.branch_taken && !out_data.reg_written && !out_data.mem_request)
    else $error("error result with side effect");

  // memory fields are zero without a request
  a_mem_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.mem_request |->
      !out_data.mem_is_store && (out_data.mem_address == '0) && (out_data.store_data == '0))
    else $error("memory fields set without request");

  // write value is zero without a register write
  a_wr_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.reg_written |-> (out_data.write_value == '0))
    else $error("write value set without register write");

endmodule

bind mips_subset_execute_unit mse_checker u_mse_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire
